// ===== rtl/core/obb_fat_pkg.sv =====
// Shared types and constants of the oriented-box face-axis overlap test.
// No dependencies; imported by the vector store and by the top level.
package obb_fat_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = 3;
  localparam int AXIS_COUNT = 6;
  localparam int AXIS_W     = 3;

  // Store layout: each box owns a centre slot followed by three half extents.
  localparam logic [SLOT_W-1:0] SLOT_A_CTR = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B_CTR = 3'd4;

  // Reported when no face axis separates the boxes.
  localparam logic [AXIS_W-1:0] AXIS_NONE = 3'd6;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } obb_fat_op_e;

  // Write request from the command decode into the vector store.
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] slot;
  } obb_fat_wr_t;

endpackage

// ===== rtl/core/obb_fat_store.sv =====
// Eight-entry vector store holding both boxes' centres and half extents.
// Depends on obb_fat_pkg for the slot count and the write request struct.
module obb_fat_store import obb_fat_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  obb_fat_wr_t                  wr_i,
  input  logic signed [COORD_BITS-1:0] wr_x_i,
  input  logic signed [COORD_BITS-1:0] wr_y_i,
  input  logic signed [COORD_BITS-1:0] wr_z_i,
  output logic signed [COORD_BITS-1:0] vec_o [SLOT_COUNT][3]
);

  // Every entry is read at a fixed place, so plain registers serve.
  logic signed [COORD_BITS-1:0] store_q [SLOT_COUNT][3];

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      store_q[wr_i.slot][0] <= wr_x_i;
      store_q[wr_i.slot][1] <= wr_y_i;
      store_q[wr_i.slot][2] <= wr_z_i;
    end
  end

  assign vec_o = store_q;

endmodule

// ===== rtl/core/obb_fat_dot.sv =====
// Two-stage dot product with magnitude: registered products, then a registered
// absolute value of their sum. No package dependencies.
module obb_fat_dot #(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic signed [COORD_BITS:0]   a_i [3],
  input  logic signed [COORD_BITS-1:0] b_i [3],
  output logic [2*COORD_BITS:0]        mag_o
);

  localparam int PW = 2 * COORD_BITS + 1;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] prod_q [3];
  logic signed [SW-1:0] sum;
  logic        [SW-1:0] abs_v;
  logic        [PW-1:0] mag_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= a_i[c] * b_i[c];
    end
  end

  assign sum   = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);
  // The sum of three products never reaches the most negative value, so the
  // magnitude always fits one bit narrower than the sum.
  assign abs_v = sum[SW-1] ? -sum : sum;

  always_ff @(posedge clk_i) begin
    mag_q <= abs_v[PW-1:0];
  end

  assign mag_o = mag_q;

endmodule

// ===== rtl/core/obb_face_axis_overlap_test.sv =====
// Top level of the oriented-box overlap test on the six face axes.
// Depends on obb_fat_pkg, obb_fat_store and obb_fat_dot.
//
//   channel   | direction | handshake                   | beat carries
//   ----------+-----------+-----------------------------+-------------------------------
//   command   | in        | start && !busy              | op, slot, comp_x/y/z
//   result    | out       | done_o, one cycle, no stall | overlap, separating_axis
//
// One command beat is taken in every cycle; busy is never raised.
// A load beat writes its vector into the store at the accepting edge and
// yields no result. A test beat yields one result beat, its data passing
// through the product, dot-sum, radius-sum and compare registers behind
// the store. Tests overlap in flight freely.
// Reset clears only the pipeline valid flags; the store is undefined until
// loaded. The receiver cannot stall: each result is shown for one cycle only.
module obb_face_axis_overlap_test import obb_fat_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [2:0]         slot_i,
  input  logic signed [19:0] comp_x_i,
  input  logic signed [19:0] comp_y_i,
  input  logic signed [19:0] comp_z_i,
  output logic               done_o,
  output logic               overlap_o,
  output logic [2:0]         separating_axis_o
);

  localparam int CW      = COORD_BITS;
  localparam int PW      = 2 * CW + 1;  // magnitude of one dot product
  localparam int RW      = 2 * CW + 3;  // sum of six half-extent dot magnitudes
  localparam int LATENCY = 5;

  // Command decode. The block never holds commands off.
  logic        accept;
  logic        test_acc;
  obb_fat_wr_t wr;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign test_acc = accept && (op_i == OP_TEST);
  assign wr.wr_en = accept && (op_i == OP_LOAD);
  assign wr.slot  = slot_i;

  // Vector store. Components keep their low COORD_BITS bits, taken as
  // two's complement; a wider coordinate zero-extends the port bits.
  logic signed [CW-1:0] vec [SLOT_COUNT][3];

  obb_fat_store #(
    .COORD_BITS(COORD_BITS)
  ) u_store (
    .clk_i (clk_i),
    .wr_i  (wr),
    .wr_x_i(CW'($unsigned(comp_x_i))),
    .wr_y_i(CW'($unsigned(comp_y_i))),
    .wr_z_i(CW'($unsigned(comp_z_i))),
    .vec_o (vec)
  );

  // The six half-extent vectors double as the face axes, in the order
  // A0, A1, A2, B0, B1, B2. Scaling an axis scales every projection
  // alike, so the unnormalised vectors give the same comparison.
  logic signed [CW-1:0] axis_v [AXIS_COUNT][3];
  logic signed [CW:0]   axis_w [AXIS_COUNT][3];
  logic signed [CW:0]   gap    [3];

  for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_axis
    for (genvar c = 0; c < 3; c++) begin : g_comp
      if (k < 3) begin : g_a
        assign axis_v[k][c] = vec[SLOT_A_CTR + 1 + k][c];
      end else begin : g_b
        assign axis_v[k][c] = vec[SLOT_B_CTR + k - 2][c];
      end
      assign axis_w[k][c] = {axis_v[k][c][CW-1], axis_v[k][c]};
    end
  end

  // Centre gap, one bit wider than a coordinate so that it cannot wrap.
  for (genvar c = 0; c < 3; c++) begin : g_gap
    assign gap[c] = {vec[SLOT_B_CTR][c][CW-1], vec[SLOT_B_CTR][c]}
                  - {vec[SLOT_A_CTR][c][CW-1], vec[SLOT_A_CTR][c]};
  end

  // Projection magnitudes. The projection of half extent i on axis k is
  // symmetric in i and k, so only the upper triangle of the Gram matrix is
  // built and mirrored below the diagonal.
  logic [PW-1:0] gram    [AXIS_COUNT][AXIS_COUNT];
  logic [PW-1:0] gap_mag [AXIS_COUNT];

  for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_row
    for (genvar j = 0; j < AXIS_COUNT; j++) begin : g_col
      if (j >= i) begin : g_pair
        logic [PW-1:0] mag;

        obb_fat_dot #(
          .COORD_BITS(COORD_BITS)
        ) u_dot (
          .clk_i(clk_i),
          .a_i  (axis_w[i]),
          .b_i  (axis_v[j]),
          .mag_o(mag)
        );

        assign gram[i][j] = mag;
        if (j != i) begin : g_mirror
          assign gram[j][i] = mag;
        end
      end
    end

    obb_fat_dot #(
      .COORD_BITS(COORD_BITS)
    ) u_gap_dot (
      .clk_i(clk_i),
      .a_i  (gap),
      .b_i  (axis_v[i]),
      .mag_o(gap_mag[i])
    );
  end

  // Radius sum per axis: both boxes' three projected half extents together,
  // added as a balanced tree. The gap magnitude is carried alongside.
  logic [RW-1:0] rsum_d [AXIS_COUNT];
  logic [RW-1:0] rsum_q [AXIS_COUNT];
  logic [PW-1:0] gd_q   [AXIS_COUNT];

  always_comb begin
    for (int k = 0; k < AXIS_COUNT; k++) begin
      rsum_d[k] = (RW'(gram[0][k]) + RW'(gram[1][k]))
                + (RW'(gram[2][k]) + RW'(gram[3][k]))
                + (RW'(gram[4][k]) + RW'(gram[5][k]));
    end
  end

  always_ff @(posedge clk_i) begin
    rsum_q <= rsum_d;
    gd_q   <= gap_mag;
  end

  // Compare and pick the first separating axis. Scanning from the last axis
  // down lets the lowest separating index win. Touching boxes, where radius
  // sum equals gap, count as overlapping.
  logic              overlap_d;
  logic [AXIS_W-1:0] sep_d;
  logic              overlap_q;
  logic [AXIS_W-1:0] sep_q;

  always_comb begin
    overlap_d = 1'b1;
    sep_d     = AXIS_NONE;
    for (int k = AXIS_COUNT - 1; k >= 0; k--) begin
      if (rsum_q[k] < RW'(gd_q[k])) begin
        overlap_d = 1'b0;
        sep_d     = AXIS_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= overlap_d;
    sep_q     <= sep_d;
  end

  // Valid flags follow each test beat through the pipeline.
  logic [LATENCY-1:0] pipe_d;
  logic [LATENCY-1:0] pipe_q;

  assign pipe_d = {pipe_q[LATENCY-2:0], test_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign done_o            = pipe_q[LATENCY-1];
  assign overlap_o         = overlap_q;
  assign separating_axis_o = sep_q;

  // A result reports overlap exactly when it names no separating axis.
  a_overlap_matches_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (overlap_o == (separating_axis_o == AXIS_NONE)))
    else $error("overlap flag disagrees with separating axis");

  // Every accepted test produces its result after the fixed latency.
  a_test_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_TEST) |-> ##LATENCY done_o)
    else $error("test beat produced no result");

  // No result appears without a test accepted the fixed latency before.
  a_result_has_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && op_i == OP_TEST, LATENCY))
    else $error("result beat without a matching test beat");

endmodule
